// ===== rtl/core/hsvrgb_pkg.sv =====
// Shared types, constants and helpers for the HSV to RGB converter.
// Used by every module of the converter; depends on nothing else.

package hsvrgb_pkg;

    // Widths of the working values.
    localparam int SECTOR_W = 3;
    localparam int FRACT_W  = 16;
    localparam int BYTE_W   = 8;

    // Full scale of an 8-bit level and half of it for rounding.
    localparam logic [BYTE_W-1:0] FULL8 = 8'd255;
    localparam logic [15:0]       HALF8 = 16'd127;

    // 255 * 65536, the divisor of q and t, and half of it for rounding.
    localparam logic [23:0] BIG      = 24'd16711680;
    localparam logic [31:0] HALF_BIG = 32'd8355840;

    // One unit of the sector fraction (65536), as a 17-bit value.
    localparam logic [FRACT_W:0] FRACT_ONE = 17'h10000;

    // Hue sectors, named after the color at which each one starts.
    localparam logic [SECTOR_W-1:0] SEC_RED     = 3'd0;
    localparam logic [SECTOR_W-1:0] SEC_YELLOW  = 3'd1;
    localparam logic [SECTOR_W-1:0] SEC_GREEN   = 3'd2;
    localparam logic [SECTOR_W-1:0] SEC_CYAN    = 3'd3;
    localparam logic [SECTOR_W-1:0] SEC_BLUE    = 3'd4;
    localparam logic [SECTOR_W-1:0] SEC_MAGENTA = 3'd5;

    // Input word: one HSV pixel.
    typedef struct packed {
        logic [15:0]       hue;
        logic [BYTE_W-1:0] saturation;
        logic [BYTE_W-1:0] brightness;
    } hsv_word_t;

    // Output word: one RGB pixel.
    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
    } rgb_word_t;

    // Hue split into sector and fraction, with the other two inputs.
    typedef struct packed {
        logic [SECTOR_W-1:0] sector;
        logic [FRACT_W-1:0]  fract;
        logic [BYTE_W-1:0]   sat;
        logic [BYTE_W-1:0]   val;
    } split_t;

    // The rounded levels that feed the channel selection.
    typedef struct packed {
        logic [SECTOR_W-1:0] sector;
        logic [BYTE_W-1:0]   val;
        logic [BYTE_W-1:0]   p;
        logic [BYTE_W-1:0]   q;
        logic [BYTE_W-1:0]   t;
    } level_t;

    // Floor of x / 255, exact for x below 65280; every caller stays below 65153.
    function automatic logic [BYTE_W-1:0] div255(input logic [15:0] x);
        logic [16:0] s;
        s = {1'b0, x} + 17'(x[15:8]) + 17'd1;
        return s[15:8];
    endfunction

endpackage

// ===== rtl/core/hsvrgb_split.sv =====
// First pipeline stage: scales the hue by six and splits it into sector and fraction.
// Depends on hsvrgb_pkg.

module hsvrgb_split
    import hsvrgb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  hsv_word_t word,
    input  logic      valid,
    input  logic      adv_down,
    output logic      adv,
    output split_t    split,
    output logic      split_valid
);

    logic         valid_reg;
    split_t       split_reg;
    split_t       split_next;
    logic [18:0]  h6;

    // The stage takes a word when it is empty or its content moves on.
    assign adv = !valid_reg || adv_down;

    // hue * 6 as 4*hue + 2*hue; the top three bits are the sector.
    always_comb
    begin
        h6                    = {1'b0, word.hue, 2'b00} + {2'b00, word.hue, 1'b0};
        split_next.sector     = h6[18:16];
        split_next.fract      = h6[15:0];
        split_next.sat        = word.saturation;
        split_next.val        = word.brightness;
    end

    // Valid bit of the stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= valid;
    end

    // Payload of the stage.
    always_ff @(posedge clk)
    begin
        if (adv && valid)
            split_reg <= split_next;
    end

    assign split       = split_reg;
    assign split_valid = valid_reg;

    // A held sector always names one of the six hue sectors.
    a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (split_reg.sector <= SEC_MAGENTA))
        else $error("sector out of range");

    // A held word stays put while the next stage cannot take it.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !adv_down) |=> (valid_reg && $stable(split_reg)))
        else $error("split stage lost its word under stall");

endmodule

// ===== rtl/core/hsvrgb_levels.sv =====
// Stages two to four: products, scaled products, and rounded levels p, q and t.
// Depends on hsvrgb_pkg.

module hsvrgb_levels
    import hsvrgb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  split_t split,
    input  logic   valid,
    input  logic   adv_down,
    output logic   adv,
    output level_t level,
    output logic   level_valid
);

    // Stage two: products with saturation.
    logic                v2_reg;
    logic [SECTOR_W-1:0] sector2_reg;
    logic [BYTE_W-1:0]   val2_reg;
    logic [23:0]         fs2_reg;
    logic [24:0]         gs2_reg;
    logic [15:0]         pv2_reg;
    logic [FRACT_W:0]    rest;
    logic [23:0]         fs_next;
    logic [24:0]         gs_next;
    logic [15:0]         pv_next;

    // Stage three: value times the q and t numerators, and p.
    logic                v3_reg;
    logic [SECTOR_W-1:0] sector3_reg;
    logic [BYTE_W-1:0]   val3_reg;
    logic [31:0]         prod_q3_reg;
    logic [31:0]         prod_t3_reg;
    logic [BYTE_W-1:0]   p3_reg;
    logic [23:0]         num_q;
    logic [23:0]         num_t;
    logic [31:0]         prod_q_next;
    logic [31:0]         prod_t_next;
    logic [BYTE_W-1:0]   p_next;

    // Stage four: rounded q and t.
    logic                v4_reg;
    level_t              lvl4_reg;
    level_t              lvl4_next;
    logic [31:0]         sum_q;
    logic [31:0]         sum_t;

    logic                adv2;
    logic                adv3;
    logic                adv4;

    // Each stage moves when it is empty or the stage after it moves.
    assign adv4 = !v4_reg || adv_down;
    assign adv3 = !v3_reg || adv4;
    assign adv2 = !v2_reg || adv3;
    assign adv  = adv2;

    // Stage two: fract*S, (1 - fract)*S and V*(255 - S).
    always_comb
    begin
        rest    = FRACT_ONE - {1'b0, split.fract};
        fs_next = 24'(split.fract) * 24'(split.sat);
        gs_next = 25'(rest) * 25'(split.sat);
        pv_next = 16'(split.val) * 16'(FULL8 - split.sat);
    end

    // Stage three: numerators of q and t, and p rounded to nearest.
    always_comb
    begin
        num_q       = BIG - fs2_reg;
        num_t       = 24'({1'b0, BIG} - gs2_reg);
        prod_q_next = 32'(val2_reg) * 32'(num_q);
        prod_t_next = 32'(val2_reg) * 32'(num_t);
        p_next      = div255(pv2_reg + HALF8);
    end

    // Stage four: divide by 255*65536 as a shift by 16 and a divide by 255.
    always_comb
    begin
        sum_q            = prod_q3_reg + HALF_BIG;
        sum_t            = prod_t3_reg + HALF_BIG;
        lvl4_next.sector = sector3_reg;
        lvl4_next.val    = val3_reg;
        lvl4_next.p      = p3_reg;
        lvl4_next.q      = div255(sum_q[31:16]);
        lvl4_next.t      = div255(sum_t[31:16]);
    end

    // Valid bits travel with the words.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv2)
                v2_reg <= valid;
            if (adv3)
                v3_reg <= v2_reg;
            if (adv4)
                v4_reg <= v3_reg;
        end
    end

    // Payload registers of the three stages.
    always_ff @(posedge clk)
    begin
        if (adv2 && valid)
        begin
            sector2_reg <= split.sector;
            val2_reg    <= split.val;
            fs2_reg     <= fs_next;
            gs2_reg     <= gs_next;
            pv2_reg     <= pv_next;
        end
        if (adv3 && v2_reg)
        begin
            sector3_reg <= sector2_reg;
            val3_reg    <= val2_reg;
            prod_q3_reg <= prod_q_next;
            prod_t3_reg <= prod_t_next;
            p3_reg      <= p_next;
        end
        if (adv4 && v3_reg)
            lvl4_reg <= lvl4_next;
    end

    assign level       = lvl4_reg;
    assign level_valid = v4_reg;

    // Every level lies between zero and the value.
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg |-> (lvl4_reg.p <= lvl4_reg.val && lvl4_reg.q <= lvl4_reg.val
                    && lvl4_reg.t <= lvl4_reg.val))
        else $error("level exceeds value");

    // A word in stage three reaches stage four when that stage moves.
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && adv4) |=> v4_reg)
        else $error("word dropped between stages three and four");

endmodule

// ===== rtl/core/hsv_to_rgb_converter.sv =====
// Top level of the HSV to RGB converter: input stage, level pipeline, output select.
// Depends on hsvrgb_pkg, hsvrgb_split and hsvrgb_levels.
//
// Usage:
//   The hsv channel carries one pixel word (hue, saturation, brightness); it is
//   taken at a clock edge where hsv_valid is high and hsv_stall is low. The rgb
//   channel returns one word (red, green, blue) per pixel, in order, taken at an
//   edge where rgb_valid is high and rgb_stall is low.
//   Path: the result reaches the output register through five register stages
//   (split, products, scaled products, rounded levels, channel select).
//   Throughput: one pixel per cycle while rgb_stall is low; every stage holds
//   one word and moves when it is empty or the stage after it moves.
//   Stall: while rgb_stall holds a valid output, the words behind it close up
//   into empty stages; hsv_stall rises once the first stage is full and cannot
//   move. Nothing is lost or repeated.
//   Reset: rst_n clears every valid bit; the payload registers are not reset, and
//   the block is ready for a pixel as soon as reset is released.

module hsv_to_rgb_converter
    import hsvrgb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  hsv_word_t hsv,
    input  logic      hsv_valid,
    output logic      hsv_stall,
    output rgb_word_t rgb,
    output logic      rgb_valid,
    input  logic      rgb_stall
);

    split_t    split;
    logic      split_valid;
    logic      split_adv;
    level_t    level;
    logic      level_valid;
    logic      level_adv;
    logic      out_adv;
    logic      out_valid_reg;
    rgb_word_t out_reg;
    rgb_word_t out_next;

    // Input stage.
    hsvrgb_split u_split (
        .clk         (clk),
        .rst_n       (rst_n),
        .word        (hsv),
        .valid       (hsv_valid),
        .adv_down    (level_adv),
        .adv         (split_adv),
        .split       (split),
        .split_valid (split_valid)
    );

    // Level pipeline.
    hsvrgb_levels u_levels (
        .clk         (clk),
        .rst_n       (rst_n),
        .split       (split),
        .valid       (split_valid),
        .adv_down    (out_adv),
        .adv         (level_adv),
        .level       (level),
        .level_valid (level_valid)
    );

    assign hsv_stall = !split_adv;
    assign out_adv   = !out_valid_reg || !rgb_stall;

    // The sector picks which level drives each channel.
    always_comb
    begin
        case (level.sector)
            SEC_RED:
            begin
                out_next.red   = level.val;
                out_next.green = level.t;
                out_next.blue  = level.p;
            end
            SEC_YELLOW:
            begin
                out_next.red   = level.q;
                out_next.green = level.val;
                out_next.blue  = level.p;
            end
            SEC_GREEN:
            begin
                out_next.red   = level.p;
                out_next.green = level.val;
                out_next.blue  = level.t;
            end
            SEC_CYAN:
            begin
                out_next.red   = level.p;
                out_next.green = level.q;
                out_next.blue  = level.val;
            end
            SEC_BLUE:
            begin
                out_next.red   = level.t;
                out_next.green = level.p;
                out_next.blue  = level.val;
            end
            default:
            begin
                out_next.red   = level.val;
                out_next.green = level.p;
                out_next.blue  = level.q;
            end
        endcase
    end

    // Output valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_adv)
            out_valid_reg <= level_valid;
    end

    // Output word.
    always_ff @(posedge clk)
    begin
        if (out_adv && level_valid)
            out_reg <= out_next;
    end

    assign rgb       = out_reg;
    assign rgb_valid = out_valid_reg;

    // A finished level word always lands in the output register when it moves.
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (level_valid && out_adv) |=> out_valid_reg)
        else $error("result dropped at output stage");

    // The input is refused only when the whole path is blocked downstream.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_stall |-> (split_valid && level_valid && out_valid_reg && rgb_stall))
        else $error("input stalled with room in the pipeline");

endmodule
